[hw/rtl/svmc_pkg.sv]
// ----------------------------------------------------------------------------
// svmc_pkg
// Shared types, constants and helpers of the swept-sphere voxel motion checker.
// ----------------------------------------------------------------------------
`default_nettype none

package svmc_pkg;

   // Map geometry
   localparam int MAX_MAP_X  = 64;
   localparam int MAX_MAP_Y  = 64;
   localparam int MAX_MAP_Z  = 16;
   localparam int MAX_RADIUS = 8;
   localparam int X_BITS     = 6;
   localparam int Y_BITS     = 6;
   localparam int Z_BITS     = 4;
   localparam int ADDR_BITS  = X_BITS + Y_BITS + Z_BITS;
   localparam int MAP_DEPTH  = MAX_MAP_X * MAX_MAP_Y * MAX_MAP_Z;

   // Request codes
   localparam logic [2:0] REQ_LOAD = 3'd0;
   localparam logic [2:0] REQ_POSE = 3'd1;
   localparam logic [2:0] REQ_FWD  = 3'd2;
   localparam logic [2:0] REQ_ROT  = 3'd3;
   localparam logic [2:0] REQ_ELEV = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_HIT     = 2'd2;
   localparam logic [1:0] ST_LIMIT   = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_RADIUS = 3'd0;
   localparam logic [2:0] CSR_ROTLIM = 3'd1;
   localparam logic [2:0] CSR_ADVLIM = 3'd2;
   localparam logic [2:0] CSR_ELVLIM = 3'd3;
   localparam logic [2:0] CSR_SIZE_X = 3'd4;
   localparam logic [2:0] CSR_SIZE_Y = 3'd5;
   localparam logic [2:0] CSR_SIZE_Z = 3'd6;

   typedef enum logic [2:0] {
      M_IDLE,
      M_EXEC,
      M_SAMPLE,
      M_WAIT,
      M_FINISH
   } main_state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_RUN,
      SC_DRAIN
   } scan_state_type;

   // Outcome of one sphere scan, valid for one cycle when done is high.
   typedef struct packed {
      logic done;
      logic fail;
   } scan_res_type;

   // Rounded cosine of the heading.
   function automatic logic signed [1:0] step_x(input logic [8:0] h);
      logic signed [1:0] s;
      if (h <= 9'd60 || h >= 9'd300) begin
         s = 2'sd1;
      end else if (h >= 9'd120 && h <= 9'd240) begin
         s = -2'sd1;
      end else begin
         s = 2'sd0;
      end
      return s;
   endfunction

   // Rounded sine of the heading.
   function automatic logic signed [1:0] step_y(input logic [8:0] h);
      logic signed [1:0] s;
      if (h >= 9'd30 && h <= 9'd150) begin
         s = 2'sd1;
      end else if (h >= 9'd210 && h <= 9'd330) begin
         s = -2'sd1;
      end else begin
         s = 2'sd0;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/svmc_map_ram.sv]
// ----------------------------------------------------------------------------
// svmc_map_ram
// One-bit free-map memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svmc_map_ram (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [svmc_pkg::ADDR_BITS-1:0] wr_addr,
   input  wire logic                           wr_data,
   input  wire logic                           rd_en,
   input  wire logic [svmc_pkg::ADDR_BITS-1:0] rd_addr,
   output logic                                rd_data
);

   logic mem [svmc_pkg::MAP_DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/svmc_sphere_scan.sv]
// ----------------------------------------------------------------------------
// svmc_sphere_scan
// Walks the cube around one sample and checks every voxel inside the sphere.
// ----------------------------------------------------------------------------
`default_nettype none

module svmc_sphere_scan (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic signed [15:0]             cx,
   input  wire logic signed [15:0]             cy,
   input  wire logic signed [15:0]             cz,
   input  wire logic [3:0]                     rad,
   input  wire logic [6:0]                     sx,
   input  wire logic [6:0]                     sy,
   input  wire logic [6:0]                     sz,
   output logic                                rd_en,
   output logic [svmc_pkg::ADDR_BITS-1:0]      rd_addr,
   input  wire logic                           rd_data,
   output svmc_pkg::scan_res_type              res
);

   svmc_pkg::scan_state_type state_ff, state_in;

   logic signed [15:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [4:0]  dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic               pend_ff, pend_in;

   logic signed [4:0]  rs;
   logic [7:0]         r2;
   logic signed [9:0]  qx, qy, qz;
   logic [10:0]        d2;
   logic signed [17:0] px, py, pz;
   logic               insph, inb, last, fail_now;

   // Cell geometry and bounds.
   always_comb begin
      rs    = $signed({1'b0, rad});
      r2    = 8'(rad * rad);
      qx    = dx_ff * dx_ff;
      qy    = dy_ff * dy_ff;
      qz    = dz_ff * dz_ff;
      d2    = 11'(qx) + 11'(qy) + 11'(qz);
      insph = d2 < {3'b000, r2};
      px    = {{2{cx_ff[15]}}, cx_ff} + {{13{dx_ff[4]}}, dx_ff};
      py    = {{2{cy_ff[15]}}, cy_ff} + {{13{dy_ff[4]}}, dy_ff};
      pz    = {{2{cz_ff[15]}}, cz_ff} + {{13{dz_ff[4]}}, dz_ff};
      inb   = !px[17] && !py[17] && !pz[17]
              && (px < {11'b0, sx}) && (py < {11'b0, sy}) && (pz < {11'b0, sz});
      last  = (dx_ff == rs) && (dy_ff == rs) && (dz_ff == rs);
      fail_now = (insph && !inb) || (pend_ff && !rd_data);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svmc_pkg::SC_IDLE: begin
            if (start) begin
               state_in = svmc_pkg::SC_RUN;
            end
         end
         svmc_pkg::SC_RUN: begin
            if (fail_now) begin
               state_in = svmc_pkg::SC_IDLE;
            end else if (last) begin
               state_in = svmc_pkg::SC_DRAIN;
            end
         end
         svmc_pkg::SC_DRAIN: begin
            state_in = svmc_pkg::SC_IDLE;
         end
         default: begin
            state_in = svmc_pkg::SC_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      rd_en    = 1'b0;
      res.done = 1'b0;
      res.fail = 1'b0;
      case (state_ff)
         svmc_pkg::SC_RUN: begin
            rd_en    = insph && inb;
            res.done = fail_now;
            res.fail = fail_now;
         end
         svmc_pkg::SC_DRAIN: begin
            res.done = 1'b1;
            res.fail = pend_ff && !rd_data;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
      rd_addr = {pz[svmc_pkg::Z_BITS-1:0], py[svmc_pkg::Y_BITS-1:0],
                 px[svmc_pkg::X_BITS-1:0]};
   end

   // Cell counter and center capture.
   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dz_in   = dz_ff;
      pend_in = (state_ff == svmc_pkg::SC_RUN) && insph && inb;
      if (state_ff == svmc_pkg::SC_IDLE && start) begin
         cx_in = cx;
         cy_in = cy;
         cz_in = cz;
         dx_in = -rs;
         dy_in = -rs;
         dz_in = -rs;
      end else if (state_ff == svmc_pkg::SC_RUN) begin
         if (dx_ff != rs) begin
            dx_in = dx_ff + 5'sd1;
         end else begin
            dx_in = -rs;
            if (dy_ff != rs) begin
               dy_in = dy_ff + 5'sd1;
            end else begin
               dy_in = -rs;
               dz_in = dz_ff + 5'sd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svmc_pkg::SC_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
   end

endmodule

`default_nettype wire

[hw/rtl/swept_sphere_voxel_motion_checker.sv]
// ----------------------------------------------------------------------------
// swept_sphere_voxel_motion_checker
// Pose keeper that checks each move against a voxel free-map.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one command word (load voxel, set pose,
// forward, rotate, elevate); the rsp channel returns exactly one word per
// command with status, pose, the sticky crash flag and the hit sample.
// Commands are handled one at a time. Load, set pose, rotate, refused and
// over-limit commands pass from the execute state straight to the finishing
// state and on into the output register. A checked move scans the cube of
// S = (2r+1)^3 cells around each of its N centimetre samples, one cell per
// cycle through the single map read port. A collision ends the scan early.
// A new command is taken while the previous response waits in the output
// register; if the receiver stalls, the next response holds in the
// finishing state until the output register is free. Reset clears the pose
// and the crash flag and restores register defaults; the free map is not
// cleared and a voxel must be loaded before a move reads it. The user must
// see that registers are written over the csr port only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_sphere_voxel_motion_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   // Command channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [15:0] req_amount,
   input  wire logic signed [15:0] req_coord_x,
   input  wire logic signed [15:0] req_coord_y,
   input  wire logic signed [15:0] req_coord_z,
   input  wire logic               req_voxel_free,
   input  wire logic [8:0]         req_start_heading,
   // Response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [15:0]      rsp_pos_x,
   output logic signed [15:0]      rsp_pos_y,
   output logic signed [15:0]      rsp_pos_z,
   output logic [8:0]              rsp_heading,
   output logic                    rsp_crashed,
   output logic signed [15:0]      rsp_hit_x,
   output logic signed [15:0]      rsp_hit_y,
   output logic signed [15:0]      rsp_hit_z,
   // Register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // ---------------- registers ----------------
   logic [3:0] radius_ff;
   logic [8:0] rotlim_ff;
   logic [9:0] advlim_ff, elvlim_ff;
   logic [6:0] sizex_ff, sizey_ff;
   logic [4:0] sizez_ff;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd1;
         rotlim_ff <= 9'd90;
         advlim_ff <= 10'd100;
         elvlim_ff <= 10'd100;
         sizex_ff  <= 7'd64;
         sizey_ff  <= 7'd64;
         sizez_ff  <= 5'd16;
      end else if (csr_wr) begin
         case (paddr[4:2])
            svmc_pkg::CSR_RADIUS: radius_ff <= pwdata[3:0];
            svmc_pkg::CSR_ROTLIM: rotlim_ff <= pwdata[8:0];
            svmc_pkg::CSR_ADVLIM: advlim_ff <= pwdata[9:0];
            svmc_pkg::CSR_ELVLIM: elvlim_ff <= pwdata[9:0];
            svmc_pkg::CSR_SIZE_X: sizex_ff  <= pwdata[6:0];
            svmc_pkg::CSR_SIZE_Y: sizey_ff  <= pwdata[6:0];
            svmc_pkg::CSR_SIZE_Z: sizez_ff  <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (paddr[4:2])
         svmc_pkg::CSR_RADIUS: prdata = {28'b0, radius_ff};
         svmc_pkg::CSR_ROTLIM: prdata = {23'b0, rotlim_ff};
         svmc_pkg::CSR_ADVLIM: prdata = {22'b0, advlim_ff};
         svmc_pkg::CSR_ELVLIM: prdata = {22'b0, elvlim_ff};
         svmc_pkg::CSR_SIZE_X: prdata = {25'b0, sizex_ff};
         svmc_pkg::CSR_SIZE_Y: prdata = {25'b0, sizey_ff};
         svmc_pkg::CSR_SIZE_Z: prdata = {27'b0, sizez_ff};
         default:              prdata = 32'b0;
      endcase
   end

   // Saturated geometry settings.
   logic [3:0] rad_sat;
   logic [6:0] sx_sat, sy_sat, sz_sat;
   always_comb begin
      rad_sat = (radius_ff > 4'(svmc_pkg::MAX_RADIUS)) ? 4'(svmc_pkg::MAX_RADIUS) : radius_ff;
      sx_sat  = (sizex_ff > 7'(svmc_pkg::MAX_MAP_X)) ? 7'(svmc_pkg::MAX_MAP_X) : sizex_ff;
      sy_sat  = (sizey_ff > 7'(svmc_pkg::MAX_MAP_Y)) ? 7'(svmc_pkg::MAX_MAP_Y) : sizey_ff;
      sz_sat  = ({2'b0, sizez_ff} > 7'(svmc_pkg::MAX_MAP_Z)) ?
                7'(svmc_pkg::MAX_MAP_Z) : {2'b0, sizez_ff};
   end

   // ---------------- state ----------------
   svmc_pkg::main_state_type state_ff, state_in;

   logic [2:0]         type_ff;
   logic signed [15:0] amt_ff, rcx_ff, rcy_ff, rcz_ff;
   logic               free_ff;
   logic [8:0]         shead_ff;

   logic signed [15:0] posx_ff, posx_in, posy_ff, posy_in, posz_ff, posz_in;
   logic [8:0]         head_ff, head_in;
   logic               crash_ff, crash_in;
   logic [1:0]         stat_ff, stat_in;
   logic signed [15:0] hitx_ff, hitx_in, hity_ff, hity_in, hitz_ff, hitz_in;
   logic signed [15:0] smpx_ff, smpx_in, smpy_ff, smpy_in, smpz_ff, smpz_in;
   logic signed [15:0] dvx_ff, dvx_in, dvy_ff, dvy_in, dvz_ff, dvz_in;
   logic [10:0]        steps_ff, steps_in, cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_stat_ff;
   logic signed [15:0] rsp_px_ff, rsp_py_ff, rsp_pz_ff;
   logic [8:0]         rsp_head_ff;
   logic               rsp_crash_ff;
   logic signed [15:0] rsp_hx_ff, rsp_hy_ff, rsp_hz_ff;

   logic                             accept, slot_free, out_load, scan_start;
   logic                             map_we, map_rd_en, map_rd_data;
   logic [svmc_pkg::ADDR_BITS-1:0]   map_rd_addr, map_wr_addr;
   svmc_pkg::scan_res_type           scan_res;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // ---------------- decode helpers ----------------
   logic [16:0]        mag;
   logic               fwd, over_lim, load_inb;
   logic [9:0]         lim;
   logic signed [1:0]  ux, uy;
   logic [12:0]        w0, w1, w2, w3;
   logic [8:0]         rot_head, pose_head;

   always_comb begin
      mag = amt_ff[15] ? (17'd0 - {amt_ff[15], amt_ff}) : {amt_ff[15], amt_ff};
      fwd = (type_ff == svmc_pkg::REQ_FWD);
      lim = fwd ? advlim_ff : elvlim_ff;
      if (type_ff == svmc_pkg::REQ_ROT) begin
         over_lim = mag > {8'b0, rotlim_ff};
      end else begin
         over_lim = mag > {7'b0, lim};
      end
      ux = fwd ? (amt_ff[15] ? -svmc_pkg::step_x(head_ff) : svmc_pkg::step_x(head_ff)) : 2'sd0;
      uy = fwd ? (amt_ff[15] ? -svmc_pkg::step_y(head_ff) : svmc_pkg::step_y(head_ff)) : 2'sd0;
      // Heading plus a bounded rotation, brought back to 0..359.
      w0 = {4'b0, head_ff} + amt_ff[12:0] + 13'd720;
      w1 = (w0 >= 13'd1440) ? (w0 - 13'd1440) : w0;
      w2 = (w1 >= 13'd720) ? (w1 - 13'd720) : w1;
      w3 = (w2 >= 13'd360) ? (w2 - 13'd360) : w2;
      rot_head  = w3[8:0];
      pose_head = (shead_ff >= 9'd360) ? (shead_ff - 9'd360) : shead_ff;
      load_inb  = (rcx_ff[15:svmc_pkg::X_BITS] == '0) && (rcy_ff[15:svmc_pkg::Y_BITS] == '0)
                  && (rcz_ff[15:svmc_pkg::Z_BITS] == '0);
      map_wr_addr = {rcz_ff[svmc_pkg::Z_BITS-1:0], rcy_ff[svmc_pkg::Y_BITS-1:0],
                     rcx_ff[svmc_pkg::X_BITS-1:0]};
   end

   // ---------------- control ----------------
   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svmc_pkg::M_IDLE: begin
            if (accept) begin
               state_in = svmc_pkg::M_EXEC;
            end
         end
         svmc_pkg::M_EXEC: begin
            if ((fwd || type_ff == svmc_pkg::REQ_ELEV) && !over_lim && !crash_ff
                && !(fwd && mag == 17'd0)) begin
               state_in = svmc_pkg::M_SAMPLE;
            end else begin
               state_in = svmc_pkg::M_FINISH;
            end
         end
         svmc_pkg::M_SAMPLE: begin
            state_in = svmc_pkg::M_WAIT;
         end
         svmc_pkg::M_WAIT: begin
            if (scan_res.done) begin
               if (scan_res.fail || cnt_ff == steps_ff) begin
                  state_in = svmc_pkg::M_FINISH;
               end else begin
                  state_in = svmc_pkg::M_SAMPLE;
               end
            end
         end
         svmc_pkg::M_FINISH: begin
            if (slot_free) begin
               state_in = svmc_pkg::M_IDLE;
            end
         end
         default: begin
            state_in = svmc_pkg::M_IDLE;
         end
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready  = 1'b0;
      scan_start = 1'b0;
      out_load   = 1'b0;
      map_we     = 1'b0;
      case (state_ff)
         svmc_pkg::M_IDLE:   req_ready  = 1'b1;
         svmc_pkg::M_EXEC:   map_we     = (type_ff == svmc_pkg::REQ_LOAD) && load_inb;
         svmc_pkg::M_SAMPLE: scan_start = 1'b1;
         svmc_pkg::M_FINISH: out_load   = slot_free;
         default:            req_ready  = 1'b0;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      posx_in  = posx_ff;
      posy_in  = posy_ff;
      posz_in  = posz_ff;
      head_in  = head_ff;
      crash_in = crash_ff;
      stat_in  = stat_ff;
      hitx_in  = hitx_ff;
      hity_in  = hity_ff;
      hitz_in  = hitz_ff;
      smpx_in  = smpx_ff;
      smpy_in  = smpy_ff;
      smpz_in  = smpz_ff;
      dvx_in   = dvx_ff;
      dvy_in   = dvy_ff;
      dvz_in   = dvz_ff;
      steps_in = steps_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         svmc_pkg::M_EXEC: begin
            stat_in = svmc_pkg::ST_DONE;
            hitx_in = '0;
            hity_in = '0;
            hitz_in = '0;
            case (type_ff)
               svmc_pkg::REQ_LOAD: begin
                  stat_in = svmc_pkg::ST_DONE;
               end
               svmc_pkg::REQ_POSE: begin
                  posx_in  = rcx_ff;
                  posy_in  = rcy_ff;
                  posz_in  = rcz_ff;
                  head_in  = pose_head;
                  crash_in = 1'b0;
               end
               svmc_pkg::REQ_ROT: begin
                  if (over_lim) begin
                     stat_in = svmc_pkg::ST_LIMIT;
                  end else if (crash_ff) begin
                     stat_in = svmc_pkg::ST_REFUSED;
                  end else begin
                     head_in = rot_head;
                  end
               end
               svmc_pkg::REQ_FWD, svmc_pkg::REQ_ELEV: begin
                  if (over_lim) begin
                     stat_in = svmc_pkg::ST_LIMIT;
                  end else if (crash_ff || (fwd && mag == 17'd0)) begin
                     stat_in = svmc_pkg::ST_REFUSED;
                  end
                  // Per-sample step; a zero elevation checks the pose once.
                  dvx_in = {{14{ux[1]}}, ux};
                  dvy_in = {{14{uy[1]}}, uy};
                  if (fwd || mag == 17'd0) begin
                     dvz_in = '0;
                  end else begin
                     dvz_in = amt_ff[15] ? -16'sd1 : 16'sd1;
                  end
                  steps_in = (mag == 17'd0) ? 11'd1 : mag[10:0];
                  cnt_in   = 11'd1;
                  smpx_in  = posx_ff + {{14{ux[1]}}, ux};
                  smpy_in  = posy_ff + {{14{uy[1]}}, uy};
                  smpz_in  = (fwd || mag == 17'd0) ? posz_ff :
                             (posz_ff + (amt_ff[15] ? -16'sd1 : 16'sd1));
               end
               default: begin
                  stat_in = svmc_pkg::ST_REFUSED;
               end
            endcase
         end
         svmc_pkg::M_WAIT: begin
            if (scan_res.done) begin
               if (scan_res.fail) begin
                  crash_in = 1'b1;
                  stat_in  = svmc_pkg::ST_HIT;
                  hitx_in  = smpx_ff;
                  hity_in  = smpy_ff;
                  hitz_in  = smpz_ff;
               end else if (cnt_ff == steps_ff) begin
                  // The last sample is the end point of the move.
                  posx_in = smpx_ff;
                  posy_in = smpy_ff;
                  posz_in = smpz_ff;
               end else begin
                  smpx_in = smpx_ff + dvx_ff;
                  smpy_in = smpy_ff + dvy_ff;
                  smpz_in = smpz_ff + dvz_ff;
                  cnt_in  = cnt_ff + 11'd1;
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svmc_pkg::M_IDLE;
         rsp_valid_ff <= 1'b0;
         posx_ff      <= '0;
         posy_ff      <= '0;
         posz_ff      <= '0;
         head_ff      <= '0;
         crash_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         posx_ff      <= posx_in;
         posy_ff      <= posy_in;
         posz_ff      <= posz_in;
         head_ff      <= head_in;
         crash_ff     <= crash_in;
      end
      stat_ff  <= stat_in;
      hitx_ff  <= hitx_in;
      hity_ff  <= hity_in;
      hitz_ff  <= hitz_in;
      smpx_ff  <= smpx_in;
      smpy_ff  <= smpy_in;
      smpz_ff  <= smpz_in;
      dvx_ff   <= dvx_in;
      dvy_ff   <= dvy_in;
      dvz_ff   <= dvz_in;
      steps_ff <= steps_in;
      cnt_ff   <= cnt_in;
      if (accept) begin
         type_ff  <= req_type;
         amt_ff   <= req_amount;
         rcx_ff   <= req_coord_x;
         rcy_ff   <= req_coord_y;
         rcz_ff   <= req_coord_z;
         free_ff  <= req_voxel_free;
         shead_ff <= req_start_heading;
      end
      if (out_load) begin
         rsp_stat_ff  <= stat_ff;
         rsp_px_ff    <= posx_ff;
         rsp_py_ff    <= posy_ff;
         rsp_pz_ff    <= posz_ff;
         rsp_head_ff  <= head_ff;
         rsp_crash_ff <= crash_ff;
         rsp_hx_ff    <= hitx_ff;
         rsp_hy_ff    <= hity_ff;
         rsp_hz_ff    <= hitz_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_stat_ff;
   assign rsp_pos_x   = rsp_px_ff;
   assign rsp_pos_y   = rsp_py_ff;
   assign rsp_pos_z   = rsp_pz_ff;
   assign rsp_heading = rsp_head_ff;
   assign rsp_crashed = rsp_crash_ff;
   assign rsp_hit_x   = rsp_hx_ff;
   assign rsp_hit_y   = rsp_hy_ff;
   assign rsp_hit_z   = rsp_hz_ff;

   // ---------------- map and scanner ----------------
   svmc_map_ram u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (free_ff),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   svmc_sphere_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .cx      (smpx_ff),
      .cy      (smpy_ff),
      .cz      (smpz_ff),
      .rad     (rad_sat),
      .sx      (sx_sat),
      .sy      (sy_sat),
      .sz      (sz_sat),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data),
      .res     (scan_res)
   );

`ifndef SYNTHESIS
   // A scan result only arrives while the sequencer waits for it.
   a_scan_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> (state_ff == svmc_pkg::M_WAIT))
      else $error("scan finished outside the wait state");

   // A collision word always carries the crash flag.
   a_hit_sets_crash: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == svmc_pkg::ST_HIT) |-> rsp_crashed)
      else $error("collision reported without crash flag");

   // Hit coordinates are zero unless a collision is reported.
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != svmc_pkg::ST_HIT)
      |-> (rsp_hit_x == 16'sd0 && rsp_hit_y == 16'sd0 && rsp_hit_z == 16'sd0))
      else $error("hit coordinates set without collision");

   // The map is never written while a scan reads it.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      map_rd_en |-> !map_we)
      else $error("map write during scan");
`endif

endmodule

`default_nettype wire
